// ===== design/cdus_pkg.sv =====
// Shared types, widths and calendar constants for the civil date to epoch seconds core.
// No dependencies; used by cdus_day_count and civil_date_to_unix_seconds_core.
package cdus_pkg;

    // field widths
    localparam int YearW  = 14;
    localparam int MonthW = 4;
    localparam int DayW   = 5;
    localparam int HourW  = 5;
    localparam int MinW   = 6;
    localparam int SecW   = 6;
    localparam int EpochW = 32;

    // internal widths
    localparam int DoyW       = 9;   // day of March-based year, 0..367
    localparam int DaysW      = 23;  // days since the epoch for any 14-bit year
    localparam int TodW       = 17;  // seconds of the day, 0..86399
    localparam int ProdW      = 40;  // days * 86400 plus seconds of the day
    localparam int RecipW     = 11;
    localparam int RecipShift = 15;

    localparam logic [YearW-1:0]  EpochYear      = 14'd1970;
    // days from 0000-03-01 to 1970-01-01
    localparam logic [DaysW:0]    EpochDayOffset = 24'd719468;
    localparam logic [DaysW-1:0]  DaysPerYear    = 23'd365;
    // floor(x * 1311 / 2^15) == floor(x / 25) for every x below 4096
    localparam logic [RecipW-1:0] Recip25        = 11'd1311;
    localparam logic [TodW-1:0]   SecsPerHour    = 17'd3600;
    localparam logic [TodW-1:0]   SecsPerMin     = 17'd60;
    localparam logic [TodW-1:0]   SecsPerDay     = 17'd86400;
    localparam logic [MonthW-1:0] MonthFeb       = 4'd2;
    localparam logic [MonthW-1:0] MonthDec       = 4'd12;
    localparam logic [HourW-1:0]  HourMax        = 5'd23;
    localparam logic [MinW-1:0]   MinMax         = 6'd59;
    localparam logic [SecW-1:0]   SecMax         = 6'd59;

    typedef struct packed {
        logic             valid;
        logic             ok;
        logic [DaysW-1:0] days;
    } t_day_res;

    // Days before the first of a month in a year that starts in March,
    // i.e. (153 * mp + 2) / 5 with mp = month - 3 mod 12.
    function automatic logic [DoyW-1:0] month_offset(input logic [MonthW-1:0] month);
        logic [DoyW-1:0] off;
        case (month)
            4'd1:    off = 9'd306;
            4'd2:    off = 9'd337;
            4'd3:    off = 9'd0;
            4'd4:    off = 9'd31;
            4'd5:    off = 9'd61;
            4'd6:    off = 9'd92;
            4'd7:    off = 9'd122;
            4'd8:    off = 9'd153;
            4'd9:    off = 9'd184;
            4'd10:   off = 9'd214;
            4'd11:   off = 9'd245;
            4'd12:   off = 9'd275;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

// ===== design/cdus_day_count.sv =====
// Two-stage day count: Gregorian date to days since 1970-01-01.
// Depends on cdus_pkg.
module cdus_day_count (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [cdus_pkg::YearW-1:0]      i_year,
    input  logic [cdus_pkg::MonthW-1:0]     i_month,
    input  logic [cdus_pkg::DayW-1:0]       i_day,
    output cdus_pkg::t_day_res              o_res
);

    localparam int YearW = cdus_pkg::YearW;
    localparam int DaysW = cdus_pkg::DaysW;
    localparam int DoyW  = cdus_pkg::DoyW;
    localparam int Y4W   = YearW - 2;
    localparam int Y16W  = YearW - 4;
    localparam int RW    = cdus_pkg::RecipW;
    localparam int Q100W = Y4W + RW - cdus_pkg::RecipShift;
    localparam int Q400W = Y16W + RW - cdus_pkg::RecipShift;

    // stage 1: shifted year, year*365, century and 400-year quotients, day of year
    logic [YearW-1:0]    y;
    logic                ok_date;
    logic [Y4W+RW-1:0]   prod100;
    logic [Y16W+RW-1:0]  prod400;
    logic [DoyW-1:0]     doy;

    logic                r_vld_1, n_vld_1;
    logic                r_ok_1;
    logic [DaysW-1:0]    r_y365_1;
    logic [Y4W-1:0]      r_y4_1;
    logic [Q100W-1:0]    r_q100_1;
    logic [Q400W-1:0]    r_q400_1;
    logic [DoyW-1:0]     r_doy_1;

    // January and February belong to the previous March-based year
    assign y = i_year - ((i_month <= cdus_pkg::MonthFeb) ? {{(YearW-1){1'b0}}, 1'b1}
                                                        : {YearW{1'b0}});
    assign ok_date = (i_month != '0) && (i_month <= cdus_pkg::MonthDec) &&
                     (i_day != '0) && (i_year >= cdus_pkg::EpochYear);
    assign prod100 = {{RW{1'b0}}, y[YearW-1:2]} * {{Y4W{1'b0}}, cdus_pkg::Recip25};
    assign prod400 = {{RW{1'b0}}, y[YearW-1:4]} * {{Y16W{1'b0}}, cdus_pkg::Recip25};
    assign doy = cdus_pkg::month_offset(i_month) + {{(DoyW-cdus_pkg::DayW){1'b0}}, i_day}
                 - {{(DoyW-1){1'b0}}, 1'b1};
    assign n_vld_1 = i_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_1 <= 1'b0;
        end else begin
            r_vld_1 <= n_vld_1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok_1   <= ok_date;
        r_y365_1 <= {{(DaysW-YearW){1'b0}}, y} * cdus_pkg::DaysPerYear;
        r_y4_1   <= y[YearW-1:2];
        r_q100_1 <= prod100[Y4W+RW-1:cdus_pkg::RecipShift];
        r_q400_1 <= prod400[Y16W+RW-1:cdus_pkg::RecipShift];
        r_doy_1  <= doy;
    end

    // stage 2: y*365 + y/4 - y/100 + y/400 + doy - epoch offset
    logic [DaysW:0] sum;
    logic           r_vld_2;
    logic           r_ok_2;
    logic [DaysW-1:0] r_days_2;

    assign sum = {1'b0, r_y365_1}
               + {{(DaysW+1-Y4W){1'b0}}, r_y4_1}
               + {{(DaysW+1-Q400W){1'b0}}, r_q400_1}
               + {{(DaysW+1-DoyW){1'b0}}, r_doy_1}
               - {{(DaysW+1-Q100W){1'b0}}, r_q100_1}
               - cdus_pkg::EpochDayOffset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_2 <= 1'b0;
        end else begin
            r_vld_2 <= r_vld_1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok_2   <= r_ok_1;
        r_days_2 <= sum[DaysW-1:0];
    end

    assign o_res.valid = r_vld_2;
    assign o_res.ok    = r_ok_2;
    assign o_res.days  = r_days_2;

endmodule

// ===== design/civil_date_to_unix_seconds_core.sv =====
// Top level: Gregorian date and time of day to unsigned 32-bit seconds since 1970-01-01.
// Depends on cdus_pkg and cdus_day_count.
//
// Usage:
//   Request channel: drive i_year, i_month, i_day, i_hour, i_minute, i_second and
//   pulse start. A request is taken at every rising edge where start is high and
//   busy is low; busy stays low, so a new request may arrive in every cycle.
//   Result channel: o_valid is high for exactly one cycle per request, once the
//   request has passed the four register stages, with o_epoch_seconds and o_valid_res alongside.
//   Results leave in request order.
//   Throughput is one request per cycle; the pipeline has four register stages:
//   date decode and quotients, day sum, days * 86400, final add
//   with the 32-bit range check (the output register).
//   A rejected request (month or day 0, month above 12, time field out of range, year
//   before 1970, total beyond 32 bits) returns o_epoch_seconds = 0 and o_valid_res = 0.
//   Synchronous reset clears every stage valid bit; requests in flight are dropped.
//   The receiver cannot stall; the pipeline never holds.
module civil_date_to_unix_seconds_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [cdus_pkg::YearW-1:0]      i_year,
    input  logic [cdus_pkg::MonthW-1:0]     i_month,
    input  logic [cdus_pkg::DayW-1:0]       i_day,
    input  logic [cdus_pkg::HourW-1:0]      i_hour,
    input  logic [cdus_pkg::MinW-1:0]       i_minute,
    input  logic [cdus_pkg::SecW-1:0]       i_second,
    output logic                            o_valid,
    output logic [cdus_pkg::EpochW-1:0]     o_epoch_seconds,
    output logic                            o_valid_res
);

    localparam int TodW   = cdus_pkg::TodW;
    localparam int ProdW  = cdus_pkg::ProdW;
    localparam int DaysW  = cdus_pkg::DaysW;
    localparam int EpochW = cdus_pkg::EpochW;

    logic accept;

    // every cycle can take a request
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // day count runs over stages 1 and 2
    cdus_pkg::t_day_res day_res;

    cdus_day_count u_day_count (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_year  (i_year),
        .i_month (i_month),
        .i_day   (i_day),
        .o_res   (day_res)
    );

    // stage 1: time of day in seconds, range check on hour, minute and second
    logic [TodW-1:0] tod;
    logic            tod_ok;
    logic [TodW-1:0] r_tod_1, r_tod_2, r_tod_3;
    logic            r_tod_ok_1, r_tod_ok_2;

    assign tod_ok = (i_hour <= cdus_pkg::HourMax) && (i_minute <= cdus_pkg::MinMax) &&
                    (i_second <= cdus_pkg::SecMax);
    assign tod = {{(TodW-cdus_pkg::HourW){1'b0}}, i_hour} * cdus_pkg::SecsPerHour
               + {{(TodW-cdus_pkg::MinW){1'b0}}, i_minute} * cdus_pkg::SecsPerMin
               + {{(TodW-cdus_pkg::SecW){1'b0}}, i_second};

    // hold the time of day beside the day count so both reach stage 3 together
    always_ff @(posedge i_clk) begin
        r_tod_1    <= tod;
        r_tod_ok_1 <= tod_ok;
        r_tod_2    <= r_tod_1;
        r_tod_ok_2 <= r_tod_ok_1;
    end

    // stage 3: days * 86400
    logic             r_vld_3;
    logic             r_ok_3;
    logic [ProdW-1:0] r_prod_3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_3 <= 1'b0;
        end else begin
            r_vld_3 <= day_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok_3   <= day_res.ok && r_tod_ok_2;
        r_prod_3 <= {{(ProdW-DaysW){1'b0}}, day_res.days} *
                    {{(ProdW-TodW){1'b0}}, cdus_pkg::SecsPerDay};
        r_tod_3  <= r_tod_2;
    end

    // stage 4: add the time of day, reject anything beyond 32 bits, register out
    logic [ProdW-1:0]  total;
    logic              n_ok_4;
    logic              r_vld_4;
    logic              r_ok_4;
    logic [EpochW-1:0] r_secs_4;

    assign total  = r_prod_3 + {{(ProdW-TodW){1'b0}}, r_tod_3};
    assign n_ok_4 = r_ok_3 && (total[ProdW-1:EpochW] == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_4 <= 1'b0;
        end else begin
            r_vld_4 <= r_vld_3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok_4   <= n_ok_4;
        // drop the value of a rejected request
        r_secs_4 <= n_ok_4 ? total[EpochW-1:0] : '0;
    end

    assign o_valid         = r_vld_4;
    assign o_valid_res     = r_ok_4;
    assign o_epoch_seconds = r_secs_4;

    // every request comes out after the four register stages
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##4 o_valid)
        else $error("request did not produce a result after four cycles");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(accept, 4) |-> !o_valid)
        else $error("result without a matching request");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_valid_res) |-> (o_epoch_seconds == '0))
        else $error("rejected result carries nonzero seconds");

    a_hour_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_valid_res) |-> ($past(i_hour, 4) <= cdus_pkg::HourMax))
        else $error("accepted result from an out-of-range hour");

endmodule
